>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while i_rst_n is low
`define DTC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that two conditions are never true together
`define DTC_ASSERT_EXCL(lbl, a, b, msg) \
    `DTC_ASSERT(lbl, !((a) && (b)), msg)

`endif

>>> hw/rtl/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared constants, types and helpers of the domino tiling counter.
// ----------------------------------------------------------------------------
package dtc_pkg;

    // Sizing
    localparam int MAX_ROWS    = 10;
    localparam int MAX_COLUMNS = 1024;
    localparam int MASK_W      = MAX_ROWS;
    localparam int MASK_COUNT  = 1 << MASK_W;
    localparam int ROW_W       = 4;
    localparam int COL_W       = 11;
    localparam int CNT_W       = 30;

    localparam logic [CNT_W-1:0] TILE_MOD = 30'd1000000007;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_PREP,
        S_SCAN,
        S_DRAIN,
        S_WRITE,
        S_COL_END,
        S_FIN_READ,
        S_FIN_WAIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // latch job size, reset counters
        logic init_wr;   // write one entry of the starting column
        logic nxt_clear; // restart next-mask counter
        logic prep;      // set up submask walk for the next mask
        logic issue;     // read one current-mask weight
        logic nxt_wr;    // store accumulated weight for the next mask
        logic col_end;   // swap tables, count the column
        logic fin_read;  // address the empty-mask entry
        logic out_load;  // capture result
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic init_last;
        logic cur_zero;
        logic nxt_last;
        logic cols_done;
    } t_dp_sts;

    // True when every run of set bits has even length
    function automatic logic runs_even(input logic [MASK_W-1:0] x);
        logic odd;
        logic bad;
        odd = 1'b0;
        bad = 1'b0;
        for (int i = 0; i < MASK_W; i++) begin
            if (x[i]) begin
                odd = ~odd;
            end else begin
                bad = bad | odd;
                odd = 1'b0;
            end
        end
        return ~(bad | odd);
    endfunction

endpackage

>>> hw/rtl/dtc_in_if.sv
// ----------------------------------------------------------------------------
// dtc_in_if
// Request channel: one column count per item.
// ----------------------------------------------------------------------------
interface dtc_in_if
    import dtc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] column_count;

    modport source (output valid, output column_count, input ready);
    modport sink   (input valid, input column_count, output ready);
endinterface

>>> hw/rtl/dtc_out_if.sv
// ----------------------------------------------------------------------------
// dtc_out_if
// Result channel: one tiling count per item.
// ----------------------------------------------------------------------------
interface dtc_out_if
    import dtc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] tiling_count;

    modport source (output valid, output tiling_count, input ready);
    modport sink   (input valid, input tiling_count, output ready);
endinterface

>>> hw/rtl/domino_tiling_counter.sv
// ----------------------------------------------------------------------------
// domino_tiling_counter
// Domino tiling count modulo 1e9+7 by a column-by-column profile DP.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake     | Payload
// i_in     | in  | valid/ready   | column_count [10:0]
// o_out    | out | valid/ready   | tiling_count [29:0]
// cfg      | in  | i_cfg_wr_en   | i_cfg_wr_data [3:0] = row_count
//
// One item at a time. With R rows (capped at 10) and C columns (capped at
// 1024) each column walks every pair of a next mask and a submask of the cells
// that mask leaves free through the single read port of the current profile
// table, one pair per cycle.
// Reset is synchronous; no clearing pass. The output register holds one
// result, so a new item is taken while the last result waits on o_out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module domino_tiling_counter
    import dtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    dtc_in_if.sink           i_in,
    dtc_out_if.source        o_out,
    input  logic             i_cfg_wr_en,
    input  logic [ROW_W-1:0] i_cfg_wr_data
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    dtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Tables and arithmetic
    dtc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_column_count (i_in.column_count),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_tiling_count (o_out.tiling_count)
    );

    // Checks
    `DTC_ASSERT(a_busy_after_accept, (i_in.valid && i_in.ready) |=> !i_in.ready, "ready after accept")
    `DTC_ASSERT(a_valid_from_load, $rose(o_out.valid) |-> $past(w_cmd.out_load), "valid without load")
    `DTC_ASSERT_EXCL(a_one_writer, w_cmd.init_wr, w_cmd.nxt_wr, "two table writers")
endmodule

>>> hw/rtl/dtc_ram.sv
// ----------------------------------------------------------------------------
// dtc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dtc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> hw/rtl/dtc_datapath.sv
// ----------------------------------------------------------------------------
// dtc_datapath
// Profile tables, mask counters and modular accumulator.
// ----------------------------------------------------------------------------
module dtc_datapath
    import dtc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [ROW_W-1:0] i_cfg_wr_data,
    input  logic [COL_W-1:0] i_column_count,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic [CNT_W-1:0] o_tiling_count
);
    logic [ROW_W-1:0]  r_row_count;
    logic [MASK_W-1:0] r_full;
    logic [COL_W-1:0]  r_cols;
    logic [COL_W-1:0]  r_col;
    logic [MASK_W-1:0] r_idx;
    logic [MASK_W-1:0] r_nxt;
    logic [MASK_W-1:0] r_cur;
    logic [MASK_W-1:0] r_avail;
    logic [CNT_W-1:0]  r_acc;
    logic              r_bank;
    logic              r_ok_d;
    logic              r_vld_d;
    logic [CNT_W-1:0]  r_tiling_count;

    logic [ROW_W-1:0]  w_rows;
    logic [MASK_W:0]   w_span;
    logic [MASK_W-1:0] w_full;
    logic [COL_W-1:0]  w_cols;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W-1:0]  w_sum_mod;
    logic [CNT_W-1:0]  w_rd0, w_rd1, w_rd_data;
    logic [MASK_W-1:0] w_rd_addr;
    logic [MASK_W-1:0] w_wr_addr;
    logic [CNT_W-1:0]  w_wr_data;
    logic              w_we0, w_we1;

    // Row count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_W'(1);
        end else if (i_cfg_wr_en) begin
            r_row_count <= i_cfg_wr_data;
        end
    end

    // Job size with saturation
    always_comb begin
        w_rows = (r_row_count > ROW_W'(MAX_ROWS)) ? ROW_W'(MAX_ROWS) : r_row_count;
        w_span = (MASK_W+1)'(1) << w_rows;
        w_full = MASK_W'(w_span - (MASK_W+1)'(1));
        w_cols = (i_column_count > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                         : i_column_count;
    end

    // Modular accumulate of the read weight
    always_comb begin
        w_rd_data = r_bank ? w_rd1 : w_rd0;
        w_sum     = {1'b0, r_acc} + {1'b0, w_rd_data};
        w_sum_mod = (w_sum >= {1'b0, TILE_MOD}) ? CNT_W'(w_sum - {1'b0, TILE_MOD})
                                               : CNT_W'(w_sum);
    end

    // Table ports: init writes the current table, mask results go to the other
    always_comb begin
        w_rd_addr = i_cmd.fin_read ? '0 : r_cur;
        w_wr_addr = i_cmd.init_wr ? r_idx : r_nxt;
        w_wr_data = i_cmd.init_wr ? ((r_idx == '0) ? CNT_W'(1) : '0) : r_acc;
        w_we0     = (i_cmd.init_wr && !r_bank) || (i_cmd.nxt_wr && r_bank);
        w_we1     = (i_cmd.init_wr && r_bank) || (i_cmd.nxt_wr && !r_bank);
    end

    dtc_ram #(.WIDTH(CNT_W), .DEPTH(MASK_COUNT)) u_ram0 (
        .i_clk     (i_clk),
        .i_wr_en   (w_we0),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd0)
    );

    dtc_ram #(.WIDTH(CNT_W), .DEPTH(MASK_COUNT)) u_ram1 (
        .i_clk     (i_clk),
        .i_wr_en   (w_we1),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd1)
    );

    // Read pipeline flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
            r_ok_d  <= 1'b0;
        end else begin
            r_vld_d <= i_cmd.issue;
            r_ok_d  <= runs_even(r_avail & ~r_cur);
        end
    end

    // Counters, masks and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_bank <= 1'b0;
            end else if (i_cmd.col_end) begin
                r_bank <= ~r_bank;
            end
        end

        if (i_cmd.start) begin
            r_full <= w_full;
            r_cols <= w_cols;
            r_col  <= '0;
            r_idx  <= '0;
        end
        if (i_cmd.init_wr) begin
            r_idx <= r_idx + MASK_W'(1);
        end
        if (i_cmd.col_end) begin
            r_col <= r_col + COL_W'(1);
        end
        if (i_cmd.nxt_clear) begin
            r_nxt <= '0;
        end else if (i_cmd.nxt_wr) begin
            r_nxt <= r_nxt + MASK_W'(1);
        end

        // submask walk over the cells left free by the next mask
        if (i_cmd.prep) begin
            r_avail <= r_full & ~r_nxt;
            r_cur   <= r_full & ~r_nxt;
        end else if (i_cmd.issue) begin
            r_cur <= (r_cur - MASK_W'(1)) & r_avail;
        end

        if (i_cmd.prep) begin
            r_acc <= '0;
        end else if (r_vld_d && r_ok_d) begin
            r_acc <= w_sum_mod;
        end

        if (i_cmd.out_load) begin
            r_tiling_count <= w_rd_data;
        end
    end

    assign o_sts.init_last  = (r_idx == r_full);
    assign o_sts.cur_zero   = (r_cur == '0);
    assign o_sts.nxt_last   = (r_nxt == r_full);
    assign o_sts.cols_done  = (r_col == r_cols);
    assign o_tiling_count   = r_tiling_count;
endmodule

>>> hw/rtl/dtc_ctrl.sv
// ----------------------------------------------------------------------------
// dtc_ctrl
// Sequencer for init, per-column mask sweeps and result hand-off.
// ----------------------------------------------------------------------------
module dtc_ctrl
    import dtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.init_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.nxt_clear = 1'b1;
                n_state = i_sts.cols_done ? S_FIN_READ : S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.cur_zero) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.nxt_wr = 1'b1;
                n_state = i_sts.nxt_last ? S_COL_END : S_PREP;
            end
            S_COL_END: begin
                o_cmd.col_end = 1'b1;
                n_state       = S_CHECK;
            end
            S_FIN_READ: begin
                o_cmd.fin_read = 1'b1;
                n_state        = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                o_cmd.fin_read = 1'b1;
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule
